[hdl/range_list_to_bitmap_parser_macros.svh]
// Assertion macros shared by the range list parser modules.
// Every macro expects aclk and aresetn to be visible where it is used.
`ifndef RANGE_LIST_TO_BITMAP_PARSER_MACROS_SVH
`define RANGE_LIST_TO_BITMAP_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RLBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rlbp_pkg.sv]
// Package for the range list to bitmap parser: set size, character codes,
// token phase type and the bitmap hand-off struct. No dependencies.
`timescale 1ns / 1ps

package rlbp_pkg;

    localparam int SET_BITS  = 256;
    localparam int IDX_W     = $clog2(SET_BITS);
    localparam int ACC_W     = IDX_W + 1;
    localparam int WORD_W    = 64;
    localparam int OUT_WORDS = 4;
    localparam int CNT_W     = $clog2(OUT_WORDS);
    localparam int MAP_W     = OUT_WORDS * WORD_W;
    localparam int TDATA_W   = ((CNT_W + WORD_W + 7) / 8) * 8;

    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam int         RADIX    = 10;

    typedef enum logic [1:0] {
        PH_BEFORE_DOT,
        PH_AFTER_DOT,
        PH_END_FIELD
    } phase_t;

    // A finished bitmap handed from the parser to the output buffer.
    typedef struct packed {
        logic             valid;
        logic             dropped;
        logic [MAP_W-1:0] bits;
    } dump_t;

endpackage

[hdl/rlbp_core.sv]
// Character parser of the range list to bitmap parser: input register,
// token state, bitmap update and hand-off of a finished bitmap. Uses rlbp_pkg.
`timescale 1ns / 1ps
`include "range_list_to_bitmap_parser_macros.svh"

module rlbp_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] char_code
    input  logic                 s_tlast,   // last_char
    input  logic                 dump_ready,
    output rlbp_pkg::dump_t      dump
);

    localparam int ACC_W    = rlbp_pkg::ACC_W;
    localparam int IDX_W    = rlbp_pkg::IDX_W;
    localparam int SET_BITS = rlbp_pkg::SET_BITS;
    localparam int PROD_W   = ACC_W + 4;

    logic                    in_valid_reg, in_valid_next;
    logic [7:0]              in_char_reg;
    logic                    in_last_reg;

    logic [SET_BITS-1:0]     bits_reg, bits_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic                    inval_reg, inval_next;
    rlbp_pkg::phase_t        phase_reg, phase_next;
    logic [ACC_W-1:0]        start_reg, start_next;
    logic                    ovf_reg, ovf_next;

    logic                    fire;
    logic                    s_beat;
    logic                    is_space, is_comma, is_dot, is_digit;
    logic [ACC_W-1:0]        fv_pre;
    logic [PROD_W-1:0]       digit_sum;

    // Token state right after this character (before any finish on last).
    logic [ACC_W-1:0]        acc_ch;
    logic                    inval_ch;
    rlbp_pkg::phase_t        phase_ch;
    logic [ACC_W-1:0]        start_ch;

    // Inputs and outputs of the single token finish unit.
    logic                    fin_active;
    logic [ACC_W-1:0]        fin_acc;
    logic                    fin_inval;
    rlbp_pkg::phase_t        fin_phase;
    logic [ACC_W-1:0]        fin_start;
    logic [ACC_W-1:0]        fin_fv;
    logic [ACC_W-1:0]        fin_hi;
    logic [SET_BITS-1:0]     fin_mask;
    logic                    fin_ovf;

    logic [SET_BITS-1:0]     bits_upd;
    logic                    ovf_upd;

    assign fire     = in_valid_reg && (!in_last_reg || dump_ready);
    assign s_tready = !in_valid_reg || fire;
    assign s_beat   = s_tvalid && s_tready;

    assign is_space = (in_char_reg == rlbp_pkg::CH_SPACE);
    assign is_comma = (in_char_reg == rlbp_pkg::CH_COMMA);
    assign is_dot   = (in_char_reg == rlbp_pkg::CH_DOT);
    assign is_digit = (in_char_reg >= rlbp_pkg::CH_ZERO) && (in_char_reg <= rlbp_pkg::CH_NINE);
    assign fv_pre   = inval_reg ? '0 : acc_reg;

    // The digit value is the low nibble of an ASCII digit.
    assign digit_sum = PROD_W'(acc_reg) * PROD_W'(rlbp_pkg::RADIX)
                     + PROD_W'(in_char_reg[3:0]);

    always_comb begin
        acc_ch   = acc_reg;
        inval_ch = inval_reg;
        phase_ch = phase_reg;
        start_ch = start_reg;
        if (is_space) begin
            // Spaces leave the token untouched.
        end else if (is_comma) begin
            acc_ch   = '0;
            inval_ch = 1'b0;
            phase_ch = rlbp_pkg::PH_BEFORE_DOT;
            start_ch = '0;
        end else if (phase_reg == rlbp_pkg::PH_BEFORE_DOT && is_dot) begin
            start_ch = fv_pre;
            acc_ch   = '0;
            inval_ch = 1'b0;
            phase_ch = rlbp_pkg::PH_AFTER_DOT;
        end else if (phase_reg == rlbp_pkg::PH_AFTER_DOT) begin
            // The first character after the dot that is not a space or comma is skipped.
            phase_ch = rlbp_pkg::PH_END_FIELD;
        end else if (is_digit) begin
            if (digit_sum > PROD_W'(SET_BITS)) begin
                acc_ch = ACC_W'(SET_BITS);
            end else begin
                acc_ch = digit_sum[ACC_W-1:0];
            end
        end else begin
            inval_ch = 1'b1;
        end
    end

    // A comma finishes the token as it stood; a last character finishes the
    // token as it stands after the character. A comma that is also last
    // finishes twice, and the second finish sees an empty token: bit 0.
    assign fin_active = fire && (is_comma || in_last_reg);
    assign fin_acc    = is_comma ? acc_reg   : acc_ch;
    assign fin_inval  = is_comma ? inval_reg : inval_ch;
    assign fin_phase  = is_comma ? phase_reg : phase_ch;
    assign fin_start  = is_comma ? start_reg : start_ch;
    assign fin_fv     = fin_inval ? '0 : fin_acc;

    always_comb begin
        fin_mask = '0;
        fin_ovf  = 1'b0;
        fin_hi   = '0;
        case (fin_phase)
            rlbp_pkg::PH_BEFORE_DOT: begin
                if (fin_fv < ACC_W'(SET_BITS)) begin
                    fin_mask[fin_fv[IDX_W-1:0]] = 1'b1;
                end else begin
                    fin_ovf = 1'b1;
                end
            end
            rlbp_pkg::PH_AFTER_DOT, rlbp_pkg::PH_END_FIELD: begin
                fin_hi = (fin_phase == rlbp_pkg::PH_END_FIELD) ? fin_fv : '0;
                if (fin_start <= fin_hi) begin
                    if (fin_hi >= ACC_W'(SET_BITS)) begin
                        fin_ovf = 1'b1;
                        fin_hi  = ACC_W'(SET_BITS - 1);
                    end
                    for (int i = 0; i < SET_BITS; i++) begin
                        fin_mask[i] = (ACC_W'(i) >= fin_start) && (ACC_W'(i) <= fin_hi);
                    end
                end
            end
            default: begin
                fin_mask = '0;
            end
        endcase
    end

    always_comb begin
        bits_upd = bits_reg;
        ovf_upd  = ovf_reg;
        if (fin_active) begin
            bits_upd = bits_upd | fin_mask;
            ovf_upd  = ovf_upd | fin_ovf;
        end
        if (fire && is_comma && in_last_reg) begin
            bits_upd[0] = 1'b1;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_beat) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end

        bits_next  = bits_reg;
        ovf_next   = ovf_reg;
        acc_next   = acc_reg;
        inval_next = inval_reg;
        phase_next = phase_reg;
        start_next = start_reg;
        dump.valid   = 1'b0;
        dump.dropped = ovf_upd;
        dump.bits    = rlbp_pkg::MAP_W'(bits_upd);

        if (fire) begin
            if (in_last_reg) begin
                dump.valid = 1'b1;
                bits_next  = '0;
                ovf_next   = 1'b0;
                acc_next   = '0;
                inval_next = 1'b0;
                phase_next = rlbp_pkg::PH_BEFORE_DOT;
                start_next = '0;
            end else begin
                bits_next  = bits_upd;
                ovf_next   = ovf_upd;
                acc_next   = acc_ch;
                inval_next = inval_ch;
                phase_next = phase_ch;
                start_next = start_ch;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            bits_reg     <= '0;
            ovf_reg      <= 1'b0;
            acc_reg      <= '0;
            inval_reg    <= 1'b0;
            phase_reg    <= rlbp_pkg::PH_BEFORE_DOT;
            start_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            bits_reg     <= bits_next;
            ovf_reg      <= ovf_next;
            acc_reg      <= acc_next;
            inval_reg    <= inval_next;
            phase_reg    <= phase_next;
            start_reg    <= start_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    `RLBP_ASSERT_NOW(a_stall_only_on_last, !s_tready, in_valid_reg && in_last_reg && !dump_ready, "input stalled without a waiting last character")
    `RLBP_ASSERT_NOW(a_dump_only_on_last, dump.valid, in_valid_reg && in_last_reg && dump_ready, "bitmap handed off without a last character")
    `RLBP_ASSERT_NEXT(a_clear_after_dump, dump.valid, bits_reg == '0 && !ovf_reg && acc_reg == '0, "bitmap not cleared after hand-off")

endmodule

[hdl/rlbp_obuf.sv]
// Output buffer of the range list to bitmap parser: holds one finished bitmap
// and sends it as four word beats. Uses rlbp_pkg.
`timescale 1ns / 1ps
`include "range_list_to_bitmap_parser_macros.svh"

module rlbp_obuf (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rlbp_pkg::dump_t               dump,
    output logic                          dump_ready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rlbp_pkg::TDATA_W-1:0]  m_tdata,   // [1:0] word_index, [65:2] set_word
    output logic                          m_tlast,   // last_word
    output logic                          m_tuser    // index_dropped
);

    localparam int CNT_W     = rlbp_pkg::CNT_W;
    localparam int WORD_W    = rlbp_pkg::WORD_W;
    localparam int OUT_WORDS = rlbp_pkg::OUT_WORDS;

    logic                                busy_reg, busy_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic [OUT_WORDS-1:0][WORD_W-1:0]    words_reg;
    logic                                drop_reg;
    logic                                m_beat;
    logic                                final_word;

    assign dump_ready = !busy_reg;
    assign m_beat     = m_tvalid && m_tready;
    assign final_word = (cnt_reg == CNT_W'(OUT_WORDS - 1));

    assign m_tvalid = busy_reg;
    assign m_tlast  = final_word;
    assign m_tuser  = drop_reg;
    assign m_tdata  = rlbp_pkg::TDATA_W'({words_reg[cnt_reg], cnt_reg});

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (dump.valid && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (m_beat) begin
            if (final_word) begin
                busy_next = 1'b0;
                cnt_next  = '0;
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dump.valid && !busy_reg) begin
            words_reg <= dump.bits;
            drop_reg  <= dump.dropped;
        end
    end

    `RLBP_ASSERT_NOW(a_load_when_free, dump.valid, !busy_reg, "bitmap offered while buffer still sending")
    `RLBP_ASSERT_NEXT(a_word_advance, m_beat && !final_word, busy_reg && cnt_reg == $past(cnt_reg) + CNT_W'(1), "word index did not advance after a beat")
    `RLBP_ASSERT_NEXT(a_stall_hold, busy_reg && !m_tready, busy_reg && $stable(cnt_reg), "word index moved while stalled")
    `RLBP_ASSERT_NEXT(a_free_after_final, m_beat && final_word, !busy_reg, "buffer still busy after the final word")

endmodule

[hdl/range_list_to_bitmap_parser.sv]
// Range list to bitmap parser, top level. One character beat per cycle unless a last
// character stalls; the parser registers a beat, then updates its token state and bitmap
// from the input register. The first word of a list leaves once its bitmap is loaded into
// the output buffer, then four word beats follow; one bitmap is buffered, so a last
// character waits at the input while the previous bitmap still sends its four words.
// Reset (aresetn low at a clock edge) clears the bitmap, token state and flag.
`timescale 1ns / 1ps

module range_list_to_bitmap_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] char_code
    input  logic                          s_tlast,   // last_char
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rlbp_pkg::TDATA_W-1:0]  m_tdata,   // [1:0] word_index, [65:2] set_word
    output logic                          m_tlast,   // last_word
    output logic                          m_tuser    // index_dropped
);

    rlbp_pkg::dump_t dump;
    logic            dump_ready;

    rlbp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .dump_ready (dump_ready),
        .dump       (dump)
    );

    rlbp_obuf u_obuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dump       (dump),
        .dump_ready (dump_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
